@@ rtl/core/fcb_pkg.sv @@
// shared types and constants of the command frame builder
`default_nettype none
package fcb_pkg;

  localparam logic [7:0] FCB_MAX_PAYLOAD = 8'd248;
  localparam int         FCB_QDEPTH      = 4;

  localparam logic       MODE_BEGIN = 1'b0;
  localparam logic       MODE_DATA  = 1'b1;

  localparam logic [1:0] TRANSPORT_INNER = 2'd0;
  localparam logic [1:0] TRANSPORT_ROUTE_A = 2'd1;

  localparam logic [7:0] BYTE_SOF       = 8'hFF;
  localparam logic [7:0] BYTE_OUTER_TAG = 8'hFB;
  localparam logic [7:0] BYTE_ROUTE_A   = 8'h10;
  localparam logic [7:0] BYTE_ROUTE_B   = 8'h30;
  localparam logic [7:0] INNER_LEN_ADD  = 8'd3;
  localparam logic [7:0] OUTER_LEN_ADD  = 8'd7;

  // one classified item on its way from front to back
  typedef struct packed {
    logic       is_data;
    logic       wrapped;
    logic       route_b;
    logic       close;
    logic [7:0] marker;
    logic [15:0] command;
    logic [7:0] plen;
    logic [7:0] data;
    logic [7:0] chk;
  } fcb_rec_t;

endpackage
`default_nettype wire

@@ rtl/core/fcb_front.sv @@
// front end: accepts items, tracks the open frame and classifies each item
`default_nettype none
module fcb_front
  import fcb_pkg::*;
#(
  parameter logic [7:0] MAX_PAYLOAD = FCB_MAX_PAYLOAD
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [7:0]  marker,
  input  wire logic [15:0] command,
  input  wire logic [7:0]  payload_len,
  input  wire logic [1:0]  transport,
  input  wire logic [7:0]  data_byte,
  input  wire logic        q_full,
  output logic             push,
  output fcb_rec_t         push_rec
);

  logic       frame_open, frame_open_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_xor, running_xor_next;

  logic       accept;
  logic [7:0] plen_c;
  logic [7:0] len_lo;
  logic [7:0] hdr_xor;
  logic [7:0] data_xor;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign plen_c   = (payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_len;
  assign len_lo   = plen_c + INNER_LEN_ADD;
  // high length byte is taken as zero, which holds while MAX_PAYLOAD stays below 253
  assign hdr_xor  = len_lo ^ command[7:0] ^ command[15:8];
  assign data_xor = running_xor ^ data_byte;

  always_comb begin
    push_rec          = '0;
    push              = 1'b0;
    frame_open_next   = frame_open;
    bytes_left_next   = bytes_left;
    running_xor_next  = running_xor;
    push_rec.marker   = marker;
    push_rec.command  = command;
    push_rec.plen     = plen_c;
    push_rec.data     = data_byte;
    if (accept) begin
      if (mode == MODE_BEGIN) begin
        push             = 1'b1;
        push_rec.is_data = 1'b0;
        push_rec.wrapped = (transport != TRANSPORT_INNER);
        push_rec.route_b = (transport != TRANSPORT_ROUTE_A);
        push_rec.close   = (plen_c == 8'd0);
        push_rec.chk     = hdr_xor;
        bytes_left_next  = plen_c;
        frame_open_next  = (plen_c != 8'd0);
        running_xor_next = (plen_c == 8'd0) ? 8'd0 : hdr_xor;
      end else if (frame_open) begin
        push             = 1'b1;
        push_rec.is_data = 1'b1;
        push_rec.close   = (bytes_left == 8'd1);
        push_rec.chk     = data_xor;
        bytes_left_next  = bytes_left - 8'd1;
        frame_open_next  = (bytes_left != 8'd1);
        running_xor_next = (bytes_left == 8'd1) ? 8'd0 : data_xor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= 8'd0;
      running_xor <= 8'd0;
    end else begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fcb_queue.sv @@
// short queue of classified items between front and back
`default_nettype none
module fcb_queue
  import fcb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire fcb_rec_t push_rec,
  output logic          full,
  input  wire logic     pop,
  output fcb_rec_t      head_rec,
  output logic          nonempty
);

  localparam int PW = $clog2(FCB_QDEPTH);
  localparam int CW = $clog2(FCB_QDEPTH + 1);

  fcb_rec_t        slots [FCB_QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(FCB_QDEPTH));
  assign nonempty = (count != '0);
  assign head_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fcb_back.sv @@
// back end: sequences the frame bytes of each item into the output register
`default_nettype none
module fcb_back
  import fcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_nonempty,
  input  wire fcb_rec_t   head_rec,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last
);

  typedef enum logic [3:0] {
    S_IDLE, S_SOF_OUT, S_TAG, S_ROUTE, S_OLEN,
    S_SOF_IN, S_MARK, S_L0, S_L1, S_C0, S_C1, S_CHK,
    S_DATA, S_DCHK
  } step_t;

  step_t      state, state_next, start_state;
  fcb_rec_t   rec;
  logic       adv;
  logic       done;
  logic [7:0] byte_sel;
  logic       last_sel;

  assign adv = (state != S_IDLE) && (!out_valid || !out_stall);
  assign pop = q_nonempty && ((state == S_IDLE) || done);

  always_comb begin
    if (head_rec.is_data) begin
      start_state = S_DATA;
    end else if (head_rec.wrapped) begin
      start_state = S_SOF_OUT;
    end else begin
      start_state = S_SOF_IN;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    byte_sel   = 8'd0;
    last_sel   = 1'b0;
    unique case (state)
      S_IDLE:    state_next = S_IDLE;
      S_SOF_OUT: begin byte_sel = BYTE_SOF;       state_next = S_TAG;    end
      S_TAG:     begin byte_sel = BYTE_OUTER_TAG; state_next = S_ROUTE;  end
      S_ROUTE: begin
        byte_sel   = rec.route_b ? BYTE_ROUTE_B : BYTE_ROUTE_A;
        state_next = S_OLEN;
      end
      S_OLEN:    begin byte_sel = rec.plen + OUTER_LEN_ADD; state_next = S_SOF_IN; end
      S_SOF_IN:  begin byte_sel = BYTE_SOF;       state_next = S_MARK;   end
      S_MARK:    begin byte_sel = rec.marker;     state_next = S_L0;     end
      S_L0:      begin byte_sel = rec.plen + INNER_LEN_ADD; state_next = S_L1; end
      S_L1:      begin byte_sel = 8'd0;           state_next = S_C0;     end
      S_C0:      begin byte_sel = rec.command[7:0]; state_next = S_C1;   end
      S_C1: begin
        byte_sel   = rec.command[15:8];
        state_next = S_CHK;
        done       = !rec.close;
      end
      S_CHK: begin
        byte_sel = rec.chk;
        last_sel = 1'b1;
        done     = 1'b1;
      end
      S_DATA: begin
        byte_sel   = rec.data;
        state_next = S_DCHK;
        done       = !rec.close;
      end
      S_DCHK: begin
        byte_sel = rec.chk;
        last_sel = 1'b1;
        done     = 1'b1;
      end
      default:   state_next = S_IDLE;
    endcase
    // only counts as finished when the byte actually moves
    done = done && adv;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= head_rec;
    end
    if (adv) begin
      out_byte <= byte_sel;
      last     <= last_sel;
    end
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        state <= start_state;
      end else if (done) begin
        state <= S_IDLE;
      end else if (adv) begin
        state <= state_next;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_nonempty)
    else $error("pop from an empty queue");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (done && !pop) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the last byte");

  a_adv_shows: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("emitted byte not presented on the output");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (adv && last_sel) |-> done)
    else $error("checksum byte did not end the item");
`endif

endmodule
`default_nettype wire

@@ rtl/core/xor_checked_frame_builder_core.sv @@
// path: an accepted item goes via the queue and the back sequencer to the output register
// throughput: one output byte per cycle unless out_stall holds it; a begin item yields
// 6, 7, 10 or 11 bytes, a payload item 1 byte, or 2 on the byte that closes the frame
// the back sequencer sets the rate; the front keeps taking items while the queue has room
// reset: synchronous, clears the open frame, the queue and the output valid
// top level of the xor checked frame builder
`default_nettype none
module xor_checked_frame_builder_core
  import fcb_pkg::*;
#(
  parameter logic [7:0] MAX_PAYLOAD = FCB_MAX_PAYLOAD
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [7:0]  marker,
  input  wire logic [15:0] command,
  input  wire logic [7:0]  payload_len,
  input  wire logic [1:0]  transport,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last
);

  logic     q_full;
  logic     q_nonempty;
  logic     push;
  logic     pop;
  fcb_rec_t push_rec;
  fcb_rec_t head_rec;

  fcb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .marker      (marker),
    .command     (command),
    .payload_len (payload_len),
    .transport   (transport),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  fcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .head_rec (head_rec),
    .nonempty (q_nonempty)
  );

  fcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for the xor checked frame builder: random frames, predicted bytes
`default_nettype none
module tb;
  import fcb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic        mode;
    logic [7:0]  marker;
    logic [15:0] command;
    logic [7:0]  plen;
    logic [1:0]  transport;
    logic [7:0]  data;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       fin;
  } frame_octet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = MODE_BEGIN;
  logic [7:0]  marker = 8'd0;
  logic [15:0] command = 16'd0;
  logic [7:0]  payload_len = 8'd0;
  logic [1:0]  transport = TRANSPORT_INNER;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  frame_req_t   req_q[$];
  frame_octet_t frame_octets_q[$];

  // predictor state
  logic       frame_open = 1'b0;
  logic [7:0] bytes_left = 8'd0;
  logic [7:0] check_acc  = 8'd0;

  int err_count   = 0;
  int n_accepted  = 0;
  int idle_cycles = 0;
  int idle_pct;
  int stall_pct;

  xor_checked_frame_builder_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .marker      (marker),
    .command     (command),
    .payload_len (payload_len),
    .transport   (transport),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last        (last)
  );

  always #6 clk = ~clk;

  // idling phases walk along with the accepted item count
  always_comb begin
    case ((n_accepted / 40) % 5)
      1: begin idle_pct = 77; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 77; end
      3: begin idle_pct = 35; stall_pct = 35; end
      default: begin idle_pct = 0; stall_pct = 0; end
    endcase
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_octet(input logic [7:0] v, input logic f);
    frame_octet_t o;
    o.octet = v;
    o.fin   = f;
    frame_octets_q.push_back(o);
  endtask

  // expected output bytes for one accepted item
  task automatic build_frame_bytes(input frame_req_t r);
    logic [7:0]  plen;
    logic [15:0] ilen;
    if (r.mode == MODE_BEGIN) begin
      plen = (r.plen > FCB_MAX_PAYLOAD) ? FCB_MAX_PAYLOAD : r.plen;
      ilen = 16'(plen) + 16'(INNER_LEN_ADD);
      if (r.transport != TRANSPORT_INNER) begin
        push_octet(BYTE_SOF, 1'b0);
        push_octet(BYTE_OUTER_TAG, 1'b0);
        push_octet((r.transport == TRANSPORT_ROUTE_A) ? BYTE_ROUTE_A : BYTE_ROUTE_B, 1'b0);
        push_octet(plen + OUTER_LEN_ADD, 1'b0);
      end
      push_octet(BYTE_SOF, 1'b0);
      push_octet(r.marker, 1'b0);
      push_octet(ilen[7:0], 1'b0);
      push_octet(ilen[15:8], 1'b0);
      push_octet(r.command[7:0], 1'b0);
      push_octet(r.command[15:8], 1'b0);
      check_acc  = ilen[7:0] ^ ilen[15:8] ^ r.command[7:0] ^ r.command[15:8];
      bytes_left = plen;
      if (plen == 8'd0) begin
        push_octet(check_acc, 1'b1);
        frame_open = 1'b0;
        check_acc  = 8'd0;
      end else begin
        frame_open = 1'b1;
      end
    end else if (frame_open) begin
      push_octet(r.data, 1'b0);
      check_acc  = check_acc ^ r.data;
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'd0) begin
        push_octet(check_acc, 1'b1);
        frame_open = 1'b0;
        check_acc  = 8'd0;
      end
    end
  endtask

  task automatic push_begin(input logic [7:0] mk, input logic [15:0] cmd,
                            input logic [7:0] plen, input logic [1:0] tr);
    frame_req_t r;
    r.mode      = MODE_BEGIN;
    r.marker    = mk;
    r.command   = cmd;
    r.plen      = plen;
    r.transport = tr;
    r.data      = 8'($urandom);
    req_q.push_back(r);
  endtask

  task automatic push_data(input logic [7:0] d);
    frame_req_t r;
    r.mode      = MODE_DATA;
    r.marker    = 8'($urandom);
    r.command   = 16'($urandom);
    r.plen      = 8'($urandom);
    r.transport = 2'($urandom);
    r.data      = d;
    req_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    frame_req_t cur;
    frame_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.mode      = mode;
        cur.marker    = marker;
        cur.command   = command;
        cur.plen      = payload_len;
        cur.transport = transport;
        cur.data      = data_byte;
        build_frame_bytes(cur);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(1, 100) > idle_pct) begin
          nxt = req_q.pop_front();
          mode        <= nxt.mode;
          marker      <= nxt.marker;
          command     <= nxt.command;
          payload_len <= nxt.plen;
          transport   <= nxt.transport;
          data_byte   <= nxt.data;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_octet_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_octets_q.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %02h last %b", out_byte, last));
        end else begin
          want = frame_octets_q.pop_front();
          if (out_byte !== want.octet)
            note_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.octet));
          if (last !== want.fin)
            note_mismatch($sformatf("last %b, want %b (byte %02h)", last, want.fin, want.octet));
        end
      end
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_rand;
    int sel;
    int plen;
    int k;
    // directed part
    push_data(8'h5A);                            // payload with no frame open
    push_begin(8'hFF, 16'h0000, 8'd0, 2'd0);     // empty payload, each transport
    push_begin(8'h00, 16'hFFFF, 8'd0, 2'd1);
    push_begin(8'hA5, 16'h1234, 8'd0, 2'd2);
    push_begin(8'h3C, 16'h8001, 8'd0, 2'd3);
    push_begin(8'hFF, 16'hFFFF, 8'hFF, 2'd3);    // oversized length
    push_data(8'h00);
    push_data(8'hFF);
    push_begin(8'h00, 16'h0000, 8'd248, 2'd1);   // abandons the open frame
    push_data(8'h80);
    push_begin(8'h7E, 16'hABCD, 8'd1, 2'd0);
    push_data(8'hFF);
    push_data(8'h11);                            // stray after close
    push_begin(8'h01, 16'h00FF, 8'd2, 2'd2);
    push_data(8'h00);
    push_data(8'h55);
    push_begin(8'h80, 16'hFF00, 8'd128, 2'd1);
    push_data(8'h01);
    push_begin(8'h42, 16'h5AA5, 8'd3, 2'd0);
    push_data(8'hAA);
    push_data(8'hBB);
    push_data(8'hCC);

    // random part: mostly complete frames, some noise and cut-off frames
    n_rand = 0;
    while (n_rand < 225) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        plen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        push_begin(8'($urandom), 16'($urandom), 8'(plen), 2'($urandom_range(0, 3)));
        for (k = 0; k < plen; k++)
          push_data(8'($urandom));
        n_rand += 1 + plen;
      end else if (sel == 7) begin
        k = $urandom_range(1, 3);
        n_rand += k;
        for (; k > 0; k--)
          push_data(8'($urandom));
      end else begin
        plen = $urandom_range(1, 255);
        push_begin(8'($urandom), 16'($urandom), 8'(plen), 2'($urandom_range(0, 3)));
        k = $urandom_range(0, (plen - 1 < 4) ? plen - 1 : 4);
        n_rand += 1 + k;
        for (; k > 0; k--)
          push_data(8'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (req_q.size() != 0 || in_valid);
    do @(negedge clk); while (frame_octets_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/fcb_pkg.sv
rtl/core/fcb_front.sv
rtl/core/fcb_queue.sv
rtl/core/fcb_back.sv
rtl/core/xor_checked_frame_builder_core.sv
bench/tb.sv
